[src/uart_rx_idle_frame_buffer_core_assert.svh]
// Assertion macros used by the frame buffer controller.
`ifndef UART_RX_IDLE_FRAME_BUFFER_CORE_ASSERT_SVH
`define UART_RX_IDLE_FRAME_BUFFER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UIRFB_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define UIRFB_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define UIRFB_ASSERT(name, clk, rst, prop)
`define UIRFB_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

[src/uirfb_pkg.sv]
package uirfb_pkg;

   localparam int DATA_W      = 8;
   localparam int POS_W       = 6;
   localparam int LEN_W       = 7;
   localparam int IDLE_W      = 16;
   localparam int ELAPSED_W   = 17;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_TICKS  = 2'd1;

   localparam logic [LEN_W-1:0]  FRAME_LIMIT_RESET = 7'd64;
   localparam logic [IDLE_W-1:0] IDLE_TICKS_RESET  = 16'd10;

   typedef struct packed {
      logic              cmd;
      logic [DATA_W-1:0] data_byte;
      logic              consumer_accept;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] frame_byte;
      logic [POS_W-1:0]  byte_position;
      logic [LEN_W-1:0]  frame_length;
      logic              last_of_frame;
      logic              frame_cleared;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_TICK,
      ST_JUDGE,
      ST_LIMIT,
      ST_READ,
      ST_LOAD,
      ST_SEND
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type           op;
      logic [ELAPSED_W-1:0] a;
      logic [ELAPSED_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [ELAPSED_W-1:0] result;
      logic                 carry;
   } alu_rsp_type;

endpackage

[src/uirfb_alu.sv]
module uirfb_alu (
   input  uirfb_pkg::alu_req_type alu_req,
   output uirfb_pkg::alu_rsp_type alu_rsp
);
   import uirfb_pkg::*;

   logic [ELAPSED_W:0] full;

   // For a subtraction the carry is the borrow, so it is set when a < b.
   always_comb begin
      full = '0;
      unique case (alu_req.op)
         ALU_ADD: begin
            full = {1'b0, alu_req.a} + {1'b0, alu_req.b};
         end
         ALU_SUB: begin
            full = {1'b0, alu_req.a} - {1'b0, alu_req.b};
         end
      endcase
      alu_rsp.result = full[ELAPSED_W-1:0];
      alu_rsp.carry  = full[ELAPSED_W];
   end

endmodule

[src/uirfb_buffer.sv]
module uirfb_buffer #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              addr,
   input  logic [uirfb_pkg::DATA_W-1:0]   wr_data,
   output logic [uirfb_pkg::DATA_W-1:0]   rd_data
);
   import uirfb_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/uirfb_ctrl.sv]
`include "uart_rx_idle_frame_buffer_core_assert.svh"

module uirfb_ctrl #(
   parameter int BUFFER_DEPTH = 64,
   parameter int ADDR_W       = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  uirfb_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output uirfb_pkg::rsp_type                rsp_data,
   input  logic [uirfb_pkg::LEN_W-1:0]       frame_limit,
   input  logic [uirfb_pkg::IDLE_W-1:0]      idle_ticks,
   output uirfb_pkg::alu_req_type            alu_req,
   input  uirfb_pkg::alu_rsp_type            alu_rsp,
   output logic                              mem_wr_en,
   output logic                              mem_rd_en,
   output logic [ADDR_W-1:0]                 mem_addr,
   output logic [uirfb_pkg::DATA_W-1:0]      mem_wr_data,
   input  logic [uirfb_pkg::DATA_W-1:0]      mem_rd_data
);
   import uirfb_pkg::*;

   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     fill_ff, fill_in;
   logic [LEN_W-1:0]     seen_ff, seen_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [POS_W-1:0]     idx_ff, idx_in;
   logic                 clear_ff, clear_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   req_type              req_ff, req_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 fill_changed;

   assign fill_changed = (seen_ff == '0) || (fill_ff != seen_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         seen_ff      <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      clear_ff <= clear_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_data.cmd ? ST_TICK : ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            if ((fill_ff == '0) || fill_changed) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            state_in = alu_rsp.carry ? ST_LIMIT : ST_IDLE;
         end
         ST_LIMIT: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               state_in = rsp_ff.last_of_frame ? ST_IDLE : ST_READ;
            end
         end
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      seen_in      = seen_ff;
      elapsed_in   = elapsed_ff;
      idx_in       = idx_ff;
      clear_in     = clear_ff;
      rsp_valid_in = rsp_valid_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      alu_req      = '{op: ALU_ADD, a: '0, b: '0};
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_addr     = '0;
      mem_wr_data  = req_ff.data_byte;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
            end
         end
         ST_WRITE: begin
            alu_req = '{op: ALU_SUB, a: ELAPSED_W'(fill_ff), b: ELAPSED_W'(frame_limit)};
            if (alu_rsp.carry) begin
               mem_wr_en = 1'b1;
               mem_addr  = fill_ff[ADDR_W-1:0];
               fill_in   = fill_ff + 1'b1;
            end
         end
         ST_TICK: begin
            alu_req = '{op: ALU_ADD, a: elapsed_ff, b: ELAPSED_W'(1)};
            if (!alu_rsp.carry) begin
               elapsed_in = alu_rsp.result;
            end
            if ((fill_ff != '0) && fill_changed) begin
               seen_in    = fill_ff;
               elapsed_in = '0;
            end
         end
         ST_JUDGE: begin
            alu_req = '{op: ALU_SUB, a: ELAPSED_W'(idle_ticks), b: elapsed_ff};
         end
         ST_LIMIT: begin
            alu_req  = '{op: ALU_SUB, a: ELAPSED_W'(fill_ff), b: ELAPSED_W'(frame_limit)};
            clear_in = req_ff.consumer_accept || !alu_rsp.carry;
            idx_in   = '0;
         end
         ST_READ: begin
            mem_rd_en = 1'b1;
            mem_addr  = idx_ff[ADDR_W-1:0];
         end
         ST_LOAD: begin
            alu_req = '{op: ALU_ADD, a: ELAPSED_W'(idx_ff), b: ELAPSED_W'(1)};
            rsp_in.frame_byte    = mem_rd_data;
            rsp_in.byte_position = idx_ff;
            rsp_in.frame_length  = fill_ff;
            rsp_in.last_of_frame = (alu_rsp.result[LEN_W-1:0] == fill_ff);
            rsp_in.frame_cleared = clear_ff;
            rsp_valid_in         = 1'b1;
         end
         ST_SEND: begin
            alu_req = '{op: ALU_ADD, a: ELAPSED_W'(idx_ff), b: ELAPSED_W'(1)};
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last_of_frame) begin
                  elapsed_in = '0;
                  if (clear_ff) begin
                     fill_in = '0;
                  end
               end else begin
                  idx_in = alu_rsp.result[POS_W-1:0];
               end
            end
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `UIRFB_ASSERT(a_fill_in_depth, clock, reset, fill_ff <= LEN_W'(BUFFER_DEPTH))
   `UIRFB_ASSERT(a_valid_only_in_send, clock, reset, rsp_valid_ff == (state_ff == ST_SEND))
   `UIRFB_ASSERT(a_read_below_fill, clock, reset,
      (state_ff != ST_READ) || ({1'b0, idx_ff} < fill_ff))
   `UIRFB_ASSERT_NEXT(a_last_ends_run, clock, reset,
      rsp_valid_ff && rsp_ready && rsp_ff.last_of_frame, state_ff == ST_IDLE)

endmodule

[src/uart_rx_idle_frame_buffer_core.sv]
// Channel   Ports                                  Direction  Moves
// request   req_valid req_ready req_data           in         received byte or tick
// response  rsp_valid rsp_ready rsp_data           out        one byte of a delivered frame
// control   csr_valid csr_ready csr_index csr_wdata  in       frame limit and idle threshold
//
// A received byte passes the write state; a tick without delivery passes the tick
// state and sometimes the judge state. A tick that delivers a frame passes tick, judge
// and limit, then per byte a buffer read, a load of the output register and the send
// state, held while rsp_ready is low. The single adder and buffer port set this order.
// Reset clears the counters synchronously; buffer contents are left undefined.
module uart_rx_idle_frame_buffer_core #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  uirfb_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output uirfb_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [uirfb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [uirfb_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import uirfb_pkg::*;

   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   logic [LEN_W-1:0]  frame_limit_ff, frame_limit_in;
   logic [IDLE_W-1:0] idle_ticks_ff, idle_ticks_in;
   logic [LEN_W-1:0]  limit_eff;
   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;
   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_addr;
   logic [DATA_W-1:0] mem_wr_data;
   logic [DATA_W-1:0] mem_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= FRAME_LIMIT_RESET;
         idle_ticks_ff  <= IDLE_TICKS_RESET;
      end else begin
         frame_limit_ff <= frame_limit_in;
         idle_ticks_ff  <= idle_ticks_in;
      end
   end

   always_comb begin
      frame_limit_in = frame_limit_ff;
      idle_ticks_in  = idle_ticks_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_LIMIT: begin
               frame_limit_in = csr_wdata[LEN_W-1:0];
            end
            CSR_IDLE_TICKS: begin
               idle_ticks_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign limit_eff = (frame_limit_ff > LEN_W'(BUFFER_DEPTH)) ?
                      LEN_W'(BUFFER_DEPTH) : frame_limit_ff;

   uirfb_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .ADDR_W       (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .frame_limit (limit_eff),
      .idle_ticks  (idle_ticks_ff),
      .alu_req     (alu_req),
      .alu_rsp     (alu_rsp),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_data (mem_rd_data)
   );

   uirfb_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   uirfb_buffer #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

endmodule
